// File: sv/huffman_code_bit_packer_unit_defines.svh
// ============================================================================
// Assertion macros for the Huffman code bit packer
// Shared same-cycle-implication and next-cycle-implication checks.
// ============================================================================
`ifndef HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BIT_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define HCBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcbp assertion failed");

// Next-cycle implication, disabled during reset.
`define HCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcbp assertion failed");

`endif

// File: sv/hcbp_pkg.sv
// ============================================================================
// hcbp_pkg
// Field widths and function codes for the Huffman code bit packer.
// ============================================================================
package hcbp_pkg;

    localparam int unsigned FUNC_W   = 2;
    localparam int unsigned SYM_W    = 8;
    localparam int unsigned CODE_W   = 32;
    localparam int unsigned LEN_IN_W = 6;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned IN_DATA_W = 48;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_LOAD   = 2'd0;
    localparam t_func FUNC_ENCODE = 2'd1;
    localparam t_func FUNC_FLUSH  = 2'd2;

endpackage

// File: sv/huffman_code_bit_packer_unit.sv
// ============================================================================
// huffman_code_bit_packer_unit
// Table-driven Huffman encoder: code table load, MSB-first bit packing, flush.
// ============================================================================
// Usage:
//   Input stream (s side): tuser carries the function (load, encode, flush);
//   tdata carries symbol, code bits and code length. A load writes one entry
//   of the code table, an encode appends the symbol's code to the bit
//   buffer, a flush pads the leftover bits with zeros into one final byte.
//   Output stream (m side): one packed byte per transfer, earliest code bit
//   in the MSB; tlast marks the byte produced by a flush.
// Path: an encode or flush accepted into stage 1 is merged into the bit
//   buffer; its bytes are then presented on o_m_tvalid by the output register.
// Throughput: one item per cycle while each item yields at most one byte and
//   the receiver does not stall; a code spanning k bytes holds the input
//   while the bit buffer drains one byte per cycle through the output register.
// The code table is a single-port synchronous memory read on input accept;
//   a load writes it on accept, so an encode in the very next cycle sees it.
// Reset clears the per-entry valid flags (every code length reads as zero),
//   the bit buffer count and both stream stages; no clearing pass is needed.
// When the receiver stalls, the output register holds its byte, the bit
//   buffer stops draining and the input stalls once the buffer holds a full byte.
// ============================================================================
module huffman_code_bit_packer_unit #(
    parameter int unsigned MAX_CODE_LEN  = 32,
    parameter int unsigned ALPHABET_SIZE = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [7:0] symbol, [39:8] code_bits, [45:40] code_len, [47:46] zero
    input  logic [hcbp_pkg::IN_DATA_W-1:0]     i_s_tdata,
    // [1:0] func
    input  logic [hcbp_pkg::FUNC_W-1:0]        i_s_tuser,
    // output stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [7:0] out_byte
    output logic [hcbp_pkg::BYTE_W-1:0]        o_m_tdata,
    output logic                               o_m_tlast
);
    import hcbp_pkg::*;

`include "huffman_code_bit_packer_unit_defines.svh"

    localparam int unsigned CW  = MAX_CODE_LEN;              // stored code width
    localparam int unsigned LW  = $clog2(MAX_CODE_LEN + 1);  // stored length width
    localparam int unsigned EW  = CW + CODE_W;               // masking width
    localparam int unsigned AIW = $clog2(ALPHABET_SIZE);     // table index width
    localparam int unsigned AW  = MAX_CODE_LEN + 7;          // bit buffer width
    localparam int unsigned CNW = $clog2(AW + 1);            // buffer count width

    // ---------------------------------------------------------------- input
    logic [SYM_W-1:0]    in_sym;
    logic [CODE_W-1:0]   in_code;
    logic [LEN_IN_W-1:0] in_len;
    t_func               in_func;
    logic                in_accept;
    logic                in_range;
    logic [AIW-1:0]      in_idx;
    logic [6:0]          len_clamp;
    logic [EW-1:0]       code_mask;
    logic [EW-1:0]       code_ext;
    logic [CW-1:0]       wr_code;
    logic [LW-1:0]       wr_len;

    assign in_sym    = i_s_tdata[7:0];
    assign in_code   = i_s_tdata[39:8];
    assign in_len    = i_s_tdata[45:40];
    assign in_func   = i_s_tuser;
    assign in_accept = i_s_tvalid && o_s_tready;
    assign in_range  = ({1'b0, in_sym} < 9'(ALPHABET_SIZE));
    assign in_idx    = in_sym[AIW-1:0];

    // Clamp the length, keep only the low len bits of the code.
    always_comb begin
        len_clamp = ({1'b0, in_len} > 7'(MAX_CODE_LEN)) ? 7'(MAX_CODE_LEN)
                                                        : {1'b0, in_len};
        code_mask = (EW'(1) << len_clamp) - EW'(1);
        code_ext  = EW'(in_code) & code_mask;
        wr_code   = code_ext[CW-1:0];
        wr_len    = LW'(len_clamp);
    end

    // ------------------------------------------------------ code table memory
    logic [CW+LW-1:0]         mem_table [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] r_valid;
    logic [CW+LW-1:0]         r_rd_entry;
    logic                     r_rd_valid;
    logic                     wr_en;

    assign wr_en = in_accept && (in_func == FUNC_LOAD) && in_range;

    // Write and registered read on accept; read data holds while stage 1 waits.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_table[in_idx] <= {wr_len, wr_code};
        end
        if (in_accept) begin
            r_rd_entry <= mem_table[in_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[in_idx] <= 1'b1;
            end
            if (in_accept) begin
                r_rd_valid <= r_valid[in_idx];
            end
        end
    end

    // ---------------------------------------------------------------- stage 1
    logic  r_s1_valid;
    t_func r_s1_func;
    logic  r_s1_range;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_func  <= in_func;
            r_s1_range <= in_range;
        end
    end

    // ------------------------------------------------------------- bit buffer
    logic [AW-1:0]     r_acc;
    logic [CNW-1:0]    r_cnt;
    logic              r_last;
    logic [AW-1:0]     n_acc;
    logic [CNW-1:0]    n_cnt;
    logic              n_last;

    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_last;

    logic              out_load;
    logic [CNW-1:0]    cnt_after;
    logic              s1_take;
    logic [AW-1:0]     emit_shift;
    logic [2:0]        keep_cnt;
    logic [6:0]        keep_mask;
    logic [6:0]        keep_bits;
    logic [LW-1:0]     s1_len;
    logic [CW-1:0]     s1_code;
    logic [7:0]        flush_byte;

    // Drain one byte when the buffer holds a full byte and the output is free.
    assign out_load   = (r_cnt >= CNW'(8)) && (!r_out_valid || i_m_tready);
    assign cnt_after  = out_load ? (r_cnt - CNW'(8)) : r_cnt;
    assign s1_take    = r_s1_valid && (cnt_after < CNW'(8));
    assign o_s_tready = !r_s1_valid || s1_take;
    assign emit_shift = r_acc >> (r_cnt - CNW'(8));

    always_comb begin
        keep_cnt   = cnt_after[2:0];
        keep_mask  = 7'((8'd1 << keep_cnt) - 8'd1);
        keep_bits  = r_acc[6:0] & keep_mask;
        s1_len     = (r_s1_func == FUNC_ENCODE && r_s1_range && r_rd_valid)
                     ? r_rd_entry[CW+LW-1:CW] : '0;
        // Only a present symbol contributes code bits; loads and the unused
        // code see stale table data here.
        s1_code    = (s1_len != '0) ? r_rd_entry[CW-1:0] : '0;
        flush_byte = 8'({1'b0, keep_bits} << (4'd8 - {1'b0, keep_cnt}));

        n_acc  = r_acc;
        n_cnt  = cnt_after;
        n_last = r_last && !out_load;
        if (s1_take) begin
            if (r_s1_func == FUNC_FLUSH) begin
                // Pad leftover bits into one final byte; skip when empty.
                if (keep_cnt != 3'd0) begin
                    n_acc  = AW'(flush_byte);
                    n_cnt  = CNW'(8);
                    n_last = 1'b1;
                end
            end else begin
                // Append the code below the leftover bits; len zero keeps state.
                n_acc = (AW'(keep_bits) << s1_len) | AW'(s1_code);
                n_cnt = cnt_after + CNW'(s1_len);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_cnt       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_take) begin
                r_s1_valid <= 1'b0;
            end
            r_cnt  <= n_cnt;
            r_last <= n_last;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (out_load) begin
            r_out_byte <= emit_shift[7:0];
            r_out_last <= r_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    // -------------------------------------------------------------- checks
    `HCBP_ASSERT_SAME(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= CNW'(AW))
    `HCBP_ASSERT_SAME(a_last_is_byte, i_clk, i_rst_n, r_last, r_cnt == CNW'(8))
    `HCBP_ASSERT_NEXT(a_last_drain, i_clk, i_rst_n, out_load && r_last,
                      o_m_tvalid && o_m_tlast)
    `HCBP_ASSERT_NEXT(a_full_fills_out, i_clk, i_rst_n,
                      (r_cnt >= CNW'(8)) && !r_out_valid, r_out_valid)

endmodule
